// ===== sv/intcode_processor_step_defines.svh =====
// assertion macros for the intcode processor step block
// expects clk and arst_n in the scope of each use
`ifndef INTCODE_PROCESSOR_STEP_DEFINES_SVH
`define INTCODE_PROCESSOR_STEP_DEFINES_SVH

// same-cycle implication
`define ICP_ASSERT_IMP(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("icp check failed");

// next-cycle implication
`define ICP_ASSERT_NXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("icp check failed");

`endif

// ===== sv/icp_pkg.sv =====
// shared types, codes and constants of the intcode processor step block
// no dependencies
package icp_pkg;

	localparam int MEM_DEPTH   = 4096;
	localparam int QUEUE_DEPTH = 16;
	localparam int AW          = $clog2(MEM_DEPTH);
	localparam int QW          = $clog2(QUEUE_DEPTH);
	localparam int CW          = $clog2(QUEUE_DEPTH + 1);
	localparam int WORD_W      = 64;
	localparam int ADDR_W      = 12;

	localparam int             DEC_MOD      = 100000;
	localparam logic [17:0]    RECIP_100    = 18'd167773;
	localparam int             RECIP_100_SH = 24;
	localparam logic [7:0]     RECIP_10     = 8'd205;
	localparam int             RECIP_10_SH  = 11;
	localparam logic [16:0]    DEC_100      = 17'd100;
	localparam logic [9:0]     DEC_10       = 10'd10;

	localparam logic [6:0] OPC_ADD  = 7'd1;
	localparam logic [6:0] OPC_MUL  = 7'd2;
	localparam logic [6:0] OPC_IN   = 7'd3;
	localparam logic [6:0] OPC_OUT  = 7'd4;
	localparam logic [6:0] OPC_JT   = 7'd5;
	localparam logic [6:0] OPC_JF   = 7'd6;
	localparam logic [6:0] OPC_LT   = 7'd7;
	localparam logic [6:0] OPC_EQ   = 7'd8;
	localparam logic [6:0] OPC_RB   = 7'd9;
	localparam logic [6:0] OPC_HALT = 7'd99;

	localparam logic [3:0] PM_POS = 4'd0;
	localparam logic [3:0] PM_IMM = 4'd1;
	localparam logic [3:0] PM_REL = 4'd2;

	typedef enum logic [1:0] {
		REQ_LOAD, REQ_PUSH, REQ_EXEC, REQ_RESTART
	} req_t;

	typedef enum logic [2:0] {
		ST_OK, ST_WAIT, ST_HALT, ST_BAD, ST_RANGE, ST_FULL
	} status_t;

	typedef enum logic [3:0] {
		OP_ADD, OP_MUL, OP_IN, OP_OUT, OP_JT, OP_JF, OP_LT, OP_EQ, OP_RB, OP_HALT, OP_BAD
	} op_t;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_DISPATCH, S_FWAIT, S_DECODE, S_PADDR, S_PWAIT,
		S_OPRD, S_OPWAIT, S_EXEC, S_MUL, S_DONE
	} state_t;

	typedef struct packed {
		op_t        op;
		logic [3:0] md1;
		logic [3:0] md2;
		logic [3:0] md3;
	} dec_t;

	function automatic op_t op_of(logic [6:0] c);
		op_t r;
		unique case (c)
			OPC_ADD:  r = OP_ADD;
			OPC_MUL:  r = OP_MUL;
			OPC_IN:   r = OP_IN;
			OPC_OUT:  r = OP_OUT;
			OPC_JT:   r = OP_JT;
			OPC_JF:   r = OP_JF;
			OPC_LT:   r = OP_LT;
			OPC_EQ:   r = OP_EQ;
			OPC_RB:   r = OP_RB;
			OPC_HALT: r = OP_HALT;
			default:  r = OP_BAD;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] op_nparams(op_t op);
		logic [1:0] n;
		unique case (op)
			OP_ADD, OP_MUL, OP_LT, OP_EQ: n = 2'd3;
			OP_JT, OP_JF:                 n = 2'd2;
			OP_IN, OP_OUT, OP_RB:         n = 2'd1;
			default:                      n = 2'd0;
		endcase
		return n;
	endfunction

	function automatic logic [1:0] op_wparam(op_t op);
		logic [1:0] w;
		unique case (op)
			OP_ADD, OP_MUL, OP_LT, OP_EQ: w = 2'd3;
			OP_IN:                        w = 2'd1;
			default:                      w = 2'd0;
		endcase
		return w;
	endfunction

	function automatic logic [3:0] md_sel(dec_t d, logic [1:0] k);
		logic [3:0] m;
		unique case (k)
			2'd1:    m = d.md1;
			2'd2:    m = d.md2;
			default: m = d.md3;
		endcase
		return m;
	endfunction

	function automatic logic md_bad(logic [3:0] m, logic written);
		return (m > PM_REL) || (written && (m == PM_IMM));
	endfunction

endpackage

// ===== sv/intcode_processor_step.sv =====
// intcode processor step: one result item per request item, word memory in one RAM
// load, push, restart and a halted execute go from dispatch straight to the done state; a new
// request is taken only while idle; execute: fetch, decode, parameter addresses (a memory read
// for each non-immediate one), operand reads, execute, multiply steps for multiply; faults end early
// reset runs a clearing pass over all MEM_DEPTH (4096) words before the first item is taken
// depends on icp_pkg, icp_ram, icp_dec and intcode_processor_step_defines.svh
`include "intcode_processor_step_defines.svh"

module intcode_processor_step (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  logic [1:0]          mode,
	input  logic [11:0]         address,
	input  logic signed [63:0]  data,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output logic [2:0]          status,
	output logic                out_valid,
	output logic signed [63:0]  out_value,
	output logic [11:0]         next_ip
);

	localparam int AW = icp_pkg::AW;
	localparam int QW = icp_pkg::QW;
	localparam int CW = icp_pkg::CW;

	icp_pkg::state_t state_q, state_d;

	logic [AW-1:0]   clr_q;
	logic [AW-1:0]   ip_q;
	logic [63:0]     rb_q;
	logic            halted_q;
	logic [QW-1:0]   qhead_q;
	logic [CW-1:0]   qcnt_q;
	logic            rvalid_q;
	logic [1:0]      k_q;
	logic [1:0]      mcnt_q;

	icp_pkg::req_t   mode_q;
	logic [11:0]     addr_q;
	logic [63:0]     data_q;
	logic [63:0]     queue_q [icp_pkg::QUEUE_DEPTH];
	logic [AW-1:0]   adr_q [3];
	logic [63:0]     a_q, b_q, acc_q;
	icp_pkg::status_t fin_st_q, st_q;
	logic            fin_ov_q, ov_q;
	logic [63:0]     fin_val_q, oval_q;
	logic [11:0]     nip_q;

	logic            ram_we;
	logic [AW-1:0]   ram_addr;
	logic [63:0]     ram_wdata, ram_rdata;
	logic            dec_start, dec_done;
	icp_pkg::dec_t   dec;

	icp_pkg::status_t fin_st;
	logic            fin_ov;
	logic [63:0]     fin_val;

	logic            clr_last, load_bad, q_full, q_empty, instr_bad;
	logic [1:0]      n, wr, nreads, ki;
	logic [3:0]      cur_md;
	logic [AW:0]     pos, nsum;
	logic            pos_fault, pv_fault, k_last_a, taken, jfault, out_go, exec_commit;
	logic [63:0]     pv, p;
	logic [31:0]     mx, my;
	logic [AW-1:0]   nxt_ip, exec_ip;
	logic [CW:0]     slot_sum;
	logic [QW-1:0]   slot, head_nx;

	icp_ram #(
		.DEPTH (icp_pkg::MEM_DEPTH),
		.WIDTH (icp_pkg::WORD_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	icp_dec u_dec (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dec_start),
		.word   (ram_rdata),
		.done   (dec_done),
		.dec    (dec)
	);

	// datapath
	always_comb begin
		clr_last  = (clr_q == AW'(icp_pkg::MEM_DEPTH - 1));
		load_bad  = (32'(addr_q) >= 32'(icp_pkg::MEM_DEPTH));
		q_full    = (qcnt_q >= CW'(icp_pkg::QUEUE_DEPTH));
		q_empty   = (qcnt_q == '0);
		n         = icp_pkg::op_nparams(dec.op);
		wr        = icp_pkg::op_wparam(dec.op);
		nreads    = (dec.op == icp_pkg::OP_IN) ? 2'd0 : ((n >= 2'd2) ? 2'd2 : n);
		instr_bad = (dec.op == icp_pkg::OP_BAD)
			|| ((n >= 2'd1) && icp_pkg::md_bad(dec.md1, wr == 2'd1))
			|| ((n >= 2'd2) && icp_pkg::md_bad(dec.md2, wr == 2'd2))
			|| ((n >= 2'd3) && icp_pkg::md_bad(dec.md3, wr == 2'd3));
		ki        = 2'(k_q - 2'd1);
		cur_md    = icp_pkg::md_sel(dec, k_q);
		pos       = (AW+1)'(ip_q) + (AW+1)'(k_q);
		pos_fault = (pos >= (AW+1)'(icp_pkg::MEM_DEPTH));
		pv        = ram_rdata + ((cur_md == icp_pkg::PM_REL) ? rb_q : 64'd0);
		pv_fault  = (pv >= 64'(icp_pkg::MEM_DEPTH));
		k_last_a  = (k_q == n);
		nsum      = (AW+1)'(ip_q) + (AW+1)'(n) + (AW+1)'(1);
		if (nsum >= (AW+1)'(icp_pkg::MEM_DEPTH)) begin
			nsum = nsum - (AW+1)'(icp_pkg::MEM_DEPTH);
		end
		nxt_ip    = nsum[AW-1:0];
		taken     = (dec.op == icp_pkg::OP_JT) == (a_q != 64'd0);
		jfault    = (dec.op == icp_pkg::OP_JT || dec.op == icp_pkg::OP_JF) && taken
			&& (b_q >= 64'(icp_pkg::MEM_DEPTH));
		exec_ip   = ((dec.op == icp_pkg::OP_JT || dec.op == icp_pkg::OP_JF) && taken)
			? AW'(b_q) : nxt_ip;
		exec_commit = (state_q == icp_pkg::S_EXEC) && (dec.op != icp_pkg::OP_MUL)
			&& !((dec.op == icp_pkg::OP_IN) && q_empty) && !jfault;
		out_go    = !rvalid_q || rsp_ready;
		unique case (mcnt_q)
			2'd0:    begin mx = a_q[31:0];  my = b_q[31:0];  end
			2'd1:    begin mx = a_q[31:0];  my = b_q[63:32]; end
			default: begin mx = a_q[63:32]; my = b_q[31:0];  end
		endcase
		p         = 64'(mx) * 64'(my);
		slot_sum  = (CW+1)'(qhead_q) + (CW+1)'(qcnt_q);
		if (slot_sum >= (CW+1)'(icp_pkg::QUEUE_DEPTH)) begin
			slot_sum = slot_sum - (CW+1)'(icp_pkg::QUEUE_DEPTH);
		end
		slot      = QW'(slot_sum);
		head_nx   = (qhead_q == QW'(icp_pkg::QUEUE_DEPTH - 1)) ? '0 : qhead_q + QW'(1);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			icp_pkg::S_CLEAR: begin
				if (clr_last) state_d = icp_pkg::S_IDLE;
			end
			icp_pkg::S_IDLE: begin
				if (req_valid) state_d = icp_pkg::S_DISPATCH;
			end
			icp_pkg::S_DISPATCH: begin
				if (mode_q == icp_pkg::REQ_EXEC && !halted_q) state_d = icp_pkg::S_FWAIT;
				else state_d = icp_pkg::S_DONE;
			end
			icp_pkg::S_FWAIT: state_d = icp_pkg::S_DECODE;
			icp_pkg::S_DECODE: begin
				if (dec_done) begin
					if (instr_bad || n == 2'd0) state_d = icp_pkg::S_DONE;
					else state_d = icp_pkg::S_PADDR;
				end
			end
			icp_pkg::S_PADDR: begin
				if (pos_fault) state_d = icp_pkg::S_DONE;
				else if (cur_md != icp_pkg::PM_IMM) state_d = icp_pkg::S_PWAIT;
				else if (!k_last_a) state_d = icp_pkg::S_PADDR;
				else if (nreads == 2'd0) state_d = icp_pkg::S_EXEC;
				else state_d = icp_pkg::S_OPRD;
			end
			icp_pkg::S_PWAIT: begin
				if (pv_fault) state_d = icp_pkg::S_DONE;
				else if (!k_last_a) state_d = icp_pkg::S_PADDR;
				else if (nreads == 2'd0) state_d = icp_pkg::S_EXEC;
				else state_d = icp_pkg::S_OPRD;
			end
			icp_pkg::S_OPRD: state_d = icp_pkg::S_OPWAIT;
			icp_pkg::S_OPWAIT: begin
				if (k_q == nreads) state_d = icp_pkg::S_EXEC;
				else state_d = icp_pkg::S_OPRD;
			end
			icp_pkg::S_EXEC: begin
				if (dec.op == icp_pkg::OP_MUL) state_d = icp_pkg::S_MUL;
				else state_d = icp_pkg::S_DONE;
			end
			icp_pkg::S_MUL: begin
				if (mcnt_q == 2'd3) state_d = icp_pkg::S_DONE;
			end
			icp_pkg::S_DONE: begin
				if (out_go) state_d = icp_pkg::S_IDLE;
			end
			default: state_d = icp_pkg::S_CLEAR;
		endcase
	end

	// outputs
	always_comb begin
		req_ready = (state_q == icp_pkg::S_IDLE);
		dec_start = (state_q == icp_pkg::S_FWAIT);
		ram_we    = 1'b0;
		ram_addr  = ip_q;
		ram_wdata = '0;
		fin_st    = icp_pkg::ST_OK;
		fin_ov    = 1'b0;
		fin_val   = '0;
		unique case (state_q)
			icp_pkg::S_CLEAR: begin
				ram_we   = 1'b1;
				ram_addr = clr_q;
			end
			icp_pkg::S_DISPATCH: begin
				unique case (mode_q)
					icp_pkg::REQ_LOAD: begin
						ram_addr  = AW'(addr_q);
						ram_wdata = data_q;
						ram_we    = !load_bad;
						if (load_bad) fin_st = icp_pkg::ST_RANGE;
					end
					icp_pkg::REQ_PUSH: begin
						if (q_full) fin_st = icp_pkg::ST_FULL;
					end
					icp_pkg::REQ_EXEC: begin
						if (halted_q) fin_st = icp_pkg::ST_HALT;
					end
					default: ;
				endcase
			end
			icp_pkg::S_DECODE: begin
				if (instr_bad) fin_st = icp_pkg::ST_BAD;
				else if (n == 2'd0) fin_st = icp_pkg::ST_HALT;
			end
			icp_pkg::S_PADDR: begin
				ram_addr = pos[AW-1:0];
				if (pos_fault) fin_st = icp_pkg::ST_RANGE;
			end
			icp_pkg::S_PWAIT: begin
				if (pv_fault) fin_st = icp_pkg::ST_RANGE;
			end
			icp_pkg::S_OPRD: ram_addr = adr_q[ki];
			icp_pkg::S_EXEC: begin
				ram_addr = adr_q[2];
				unique case (dec.op)
					icp_pkg::OP_ADD: begin
						ram_we    = 1'b1;
						ram_wdata = a_q + b_q;
					end
					icp_pkg::OP_LT: begin
						ram_we    = 1'b1;
						ram_wdata = {63'd0, $signed(a_q) < $signed(b_q)};
					end
					icp_pkg::OP_EQ: begin
						ram_we    = 1'b1;
						ram_wdata = {63'd0, a_q == b_q};
					end
					icp_pkg::OP_IN: begin
						ram_addr  = adr_q[0];
						ram_wdata = queue_q[qhead_q];
						ram_we    = !q_empty;
						if (q_empty) fin_st = icp_pkg::ST_WAIT;
					end
					icp_pkg::OP_OUT: begin
						fin_ov  = 1'b1;
						fin_val = a_q;
					end
					icp_pkg::OP_JT, icp_pkg::OP_JF: begin
						if (jfault) fin_st = icp_pkg::ST_RANGE;
					end
					default: ;
				endcase
			end
			icp_pkg::S_MUL: begin
				ram_addr  = adr_q[2];
				ram_wdata = acc_q;
				ram_we    = (mcnt_q == 2'd3);
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= icp_pkg::S_CLEAR;
			clr_q    <= '0;
			ip_q     <= '0;
			rb_q     <= '0;
			halted_q <= 1'b0;
			qhead_q  <= '0;
			qcnt_q   <= '0;
			rvalid_q <= 1'b0;
			k_q      <= '0;
			mcnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == icp_pkg::S_CLEAR) clr_q <= clr_q + AW'(1);
			if (state_q == icp_pkg::S_DONE && out_go) rvalid_q <= 1'b1;
			else if (rsp_ready) rvalid_q <= 1'b0;
			unique case (state_q)
				icp_pkg::S_DISPATCH: begin
					if (mode_q == icp_pkg::REQ_RESTART) begin
						ip_q     <= '0;
						rb_q     <= '0;
						halted_q <= 1'b0;
						qhead_q  <= '0;
						qcnt_q   <= '0;
					end else if (mode_q == icp_pkg::REQ_PUSH && !q_full) begin
						qcnt_q <= qcnt_q + CW'(1);
					end
				end
				icp_pkg::S_DECODE: begin
					k_q <= 2'd1;
					if (dec_done && !instr_bad && n == 2'd0) halted_q <= 1'b1;
				end
				icp_pkg::S_PADDR: begin
					if (cur_md == icp_pkg::PM_IMM) k_q <= k_last_a ? 2'd1 : k_q + 2'd1;
				end
				icp_pkg::S_PWAIT: k_q <= k_last_a ? 2'd1 : k_q + 2'd1;
				icp_pkg::S_OPWAIT: k_q <= k_q + 2'd1;
				icp_pkg::S_EXEC: begin
					mcnt_q <= '0;
					if (exec_commit) begin
						ip_q <= exec_ip;
						if (dec.op == icp_pkg::OP_RB) rb_q <= rb_q + a_q;
						if (dec.op == icp_pkg::OP_IN) begin
							qhead_q <= head_nx;
							qcnt_q  <= qcnt_q - CW'(1);
						end
					end
				end
				icp_pkg::S_MUL: begin
					mcnt_q <= mcnt_q + 2'd1;
					if (mcnt_q == 2'd3) ip_q <= nxt_ip;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			mode_q <= icp_pkg::req_t'(mode);
			addr_q <= address;
			data_q <= data;
		end
		if (state_q == icp_pkg::S_DISPATCH && mode_q == icp_pkg::REQ_PUSH && !q_full) begin
			queue_q[slot] <= data_q;
		end
		if (state_q == icp_pkg::S_PADDR && !pos_fault && cur_md == icp_pkg::PM_IMM) begin
			adr_q[ki] <= pos[AW-1:0];
		end
		if (state_q == icp_pkg::S_PWAIT && !pv_fault) begin
			adr_q[ki] <= AW'(pv);
		end
		if (state_q == icp_pkg::S_OPWAIT) begin
			if (k_q == 2'd1) a_q <= ram_rdata;
			else b_q <= ram_rdata;
		end
		if (state_q == icp_pkg::S_MUL && mcnt_q != 2'd3) begin
			if (mcnt_q == 2'd0) acc_q <= p;
			else acc_q <= acc_q + {p[31:0], 32'd0};
		end
		if (state_q != icp_pkg::S_DONE && state_d == icp_pkg::S_DONE) begin
			fin_st_q  <= fin_st;
			fin_ov_q  <= fin_ov;
			fin_val_q <= fin_val;
		end
		if (state_q == icp_pkg::S_DONE && out_go) begin
			st_q   <= fin_st_q;
			ov_q   <= fin_ov_q;
			oval_q <= fin_val_q;
			nip_q  <= 12'(ip_q);
		end
	end

	assign rsp_valid = rvalid_q;
	assign status    = st_q;
	assign out_valid = ov_q;
	assign out_value = oval_q;
	assign next_ip   = nip_q;

	`ICP_ASSERT_IMP(a_clear_blocks_req, state_q == icp_pkg::S_CLEAR, !req_ready)
	`ICP_ASSERT_IMP(a_out_only_ok, rsp_valid && out_valid, status == icp_pkg::ST_OK)
	`ICP_ASSERT_IMP(a_out_zero, rsp_valid && !out_valid, out_value == 64'd0)
	`ICP_ASSERT_IMP(a_qcnt_bound, 1'b1, qcnt_q <= CW'(icp_pkg::QUEUE_DEPTH))
	`ICP_ASSERT_NXT(a_halt_holds,
		halted_q && state_q == icp_pkg::S_DISPATCH && mode_q == icp_pkg::REQ_EXEC,
		state_q == icp_pkg::S_DONE && ip_q == $past(ip_q))

endmodule

// ===== sv/icp_ram.sv =====
// single-port word memory with registered read data
// no dependencies
module icp_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ===== sv/icp_dec.sv =====
// iterative decimal decoder: opcode and three mode digits of an instruction word
// depends on icp_pkg
module icp_dec (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [icp_pkg::WORD_W-1:0]    word,
	output logic                          done,
	output icp_pkg::dec_t                 dec
);

	localparam int         NSTEP   = icp_pkg::WORD_W / 4;
	localparam logic [4:0] PH_Q100 = 5'(NSTEP);
	localparam logic [4:0] PH_DIG1 = 5'(NSTEP + 1);
	localparam logic [4:0] PH_DIG2 = 5'(NSTEP + 2);

	logic                         busy_q, done_q;
	logic [4:0]                   cnt_q;
	logic [icp_pkg::WORD_W-1:0]   w_q;
	logic [16:0]                  r_q;
	logic                         neg_q;
	logic [9:0]                   q100_q;
	logic [6:0]                   t_q;
	logic [6:0]                   opc_q;
	logic [3:0]                   m1_q;
	icp_pkg::dec_t                dec_q;

	logic [20:0] x;
	logic [3:0]  q;
	logic [34:0] prod_100;
	logic [17:0] prod_t;
	logic [14:0] prod_u;
	logic [6:0]  t_d;
	logic [3:0]  u_d;

	// one hex digit per step, remainder kept below the decimal modulus
	always_comb begin
		x = {r_q, 4'b0} + 21'(w_q[icp_pkg::WORD_W-1 -: 4]);
		q = '0;
		for (int i = 1; i < 16; i++) begin
			if (x >= 21'(i * icp_pkg::DEC_MOD)) begin
				q = q + 4'd1;
			end
		end
		prod_100 = 35'(r_q) * 35'(icp_pkg::RECIP_100);
		prod_t   = 18'(q100_q) * 18'(icp_pkg::RECIP_10);
		t_d      = 7'(prod_t >> icp_pkg::RECIP_10_SH);
		prod_u   = 15'(t_q) * 15'(icp_pkg::RECIP_10);
		u_d      = 4'(prod_u >> icp_pkg::RECIP_10_SH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == PH_DIG2);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == PH_DIG2) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			w_q   <= word;
			r_q   <= '0;
			neg_q <= word[icp_pkg::WORD_W-1];
		end else if (busy_q) begin
			if (cnt_q < PH_Q100) begin
				r_q <= 17'(x - 21'(q) * 21'(icp_pkg::DEC_MOD));
				w_q <= w_q << 4;
			end else if (cnt_q == PH_Q100) begin
				q100_q <= 10'(prod_100 >> icp_pkg::RECIP_100_SH);
			end else if (cnt_q == PH_DIG1) begin
				opc_q <= 7'(r_q - 17'(q100_q) * icp_pkg::DEC_100);
				t_q   <= t_d;
				m1_q  <= 4'(q100_q - 10'(t_d) * icp_pkg::DEC_10);
			end else begin
				dec_q.op  <= neg_q ? icp_pkg::OP_BAD : icp_pkg::op_of(opc_q);
				dec_q.md1 <= m1_q;
				dec_q.md2 <= 4'(t_q - 7'(u_d) * 7'(icp_pkg::DEC_10));
				dec_q.md3 <= u_d;
			end
		end
	end

	assign done = done_q;
	assign dec  = dec_q;

endmodule
